FILE: src/cpop_pkg.sv
// Shared widths, derived stage counts and side-data types for the circle overlap push pipeline.
package cpop_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int FRACTION_BITS = 20;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int RAD_W  = FRACTION_BITS + 1;
  localparam int CMP_W  = (DIFF_W > RAD_W) ? DIFF_W : RAD_W;
  localparam int SQ_W   = 2 * RAD_W;
  localparam int DSQ_W  = SQ_W + 1;

  localparam int ROOT_W      = RAD_W + 1;
  localparam int SQRT_STAGES = (ROOT_W + 1) / 2;
  localparam int SQRT_X_W    = 4 * SQRT_STAGES;
  localparam int REM_W       = ROOT_W + 3;

  localparam int NUM_W      = 2 * RAD_W + 1;
  localparam int DEN_W      = RAD_W + 1;
  localparam int QUO_W      = FRACTION_BITS;
  localparam int DIV_STAGES = (QUO_W + 1) / 2;

  // front (4) + root + violation/product/numerator (3) + divide + output register
  localparam int LATENCY = 4 + SQRT_STAGES + 3 + DIV_STAGES + 1;

  typedef struct packed {
    logic               contact;
    logic               sx;
    logic               sy;
    logic [RAD_W-1:0]   r;
    logic [RAD_W-1:0]   adx;
    logic [RAD_W-1:0]   ady;
  } side_t;

  typedef struct packed {
    logic contact;
    logic sx;
    logic sy;
  } sign_t;

endpackage

FILE: src/cpop_front.sv
// Front stages: differences, magnitudes and reject test, squares, contact decision.
module cpop_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [cpop_pkg::COORD_WIDTH-1:0]  in_a_x,
  input  logic [cpop_pkg::COORD_WIDTH-1:0]  in_a_y,
  input  logic [cpop_pkg::FRACTION_BITS-1:0] in_a_radius,
  input  logic [cpop_pkg::COORD_WIDTH-1:0]  in_b_x,
  input  logic [cpop_pkg::COORD_WIDTH-1:0]  in_b_y,
  input  logic [cpop_pkg::FRACTION_BITS-1:0] in_b_radius,
  output logic                              out_valid,
  output logic [cpop_pkg::DSQ_W-1:0]        out_dsq,
  output cpop_pkg::side_t                   out_side
);

  // stage 1
  logic                           v1_r;
  logic [cpop_pkg::DIFF_W-1:0]    dx1_r, dy1_r;
  logic [cpop_pkg::RAD_W-1:0]     r1_r;
  // stage 2
  logic                           v2_r;
  cpop_pkg::side_t                side2_r;
  // stage 3
  logic                           v3_r;
  cpop_pkg::side_t                side3_r;
  logic [cpop_pkg::SQ_W-1:0]      sqx3_r, sqy3_r, rsq3_r;
  // stage 4
  logic                           v4_r;
  cpop_pkg::side_t                side4_r;
  logic [cpop_pkg::DSQ_W-1:0]     dsq4_r;

  logic [cpop_pkg::DIFF_W-1:0]    dx1_nxt, dy1_nxt, adx2, ady2;
  logic                           near2;
  logic [cpop_pkg::DSQ_W-1:0]     dsq4_nxt;
  logic                           contact4_nxt;

  always_comb begin
    dx1_nxt = {in_b_x[cpop_pkg::COORD_WIDTH-1], in_b_x}
            - {in_a_x[cpop_pkg::COORD_WIDTH-1], in_a_x};
    dy1_nxt = {in_b_y[cpop_pkg::COORD_WIDTH-1], in_b_y}
            - {in_a_y[cpop_pkg::COORD_WIDTH-1], in_a_y};
  end

  always_comb begin
    adx2  = dx1_r[cpop_pkg::DIFF_W-1] ? (~dx1_r + 1'b1) : dx1_r;
    ady2  = dy1_r[cpop_pkg::DIFF_W-1] ? (~dy1_r + 1'b1) : dy1_r;
    near2 = (cpop_pkg::CMP_W'(adx2) < cpop_pkg::CMP_W'(r1_r))
         && (cpop_pkg::CMP_W'(ady2) < cpop_pkg::CMP_W'(r1_r));
  end

  always_comb begin
    dsq4_nxt     = cpop_pkg::DSQ_W'(sqx3_r) + cpop_pkg::DSQ_W'(sqy3_r);
    contact4_nxt = side3_r.contact && (dsq4_nxt != '0)
                && (dsq4_nxt < cpop_pkg::DSQ_W'(rsq3_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    dx1_r <= dx1_nxt;
    dy1_r <= dy1_nxt;
    r1_r  <= cpop_pkg::RAD_W'(in_a_radius) + cpop_pkg::RAD_W'(in_b_radius);

    side2_r.contact <= near2;
    side2_r.sx      <= dx1_r[cpop_pkg::DIFF_W-1];
    side2_r.sy      <= dy1_r[cpop_pkg::DIFF_W-1];
    side2_r.r       <= r1_r;
    side2_r.adx     <= adx2[cpop_pkg::RAD_W-1:0];
    side2_r.ady     <= ady2[cpop_pkg::RAD_W-1:0];

    side3_r <= side2_r;
    sqx3_r  <= side2_r.adx * side2_r.adx;
    sqy3_r  <= side2_r.ady * side2_r.ady;
    rsq3_r  <= side2_r.r * side2_r.r;

    side4_r.contact <= contact4_nxt;
    side4_r.sx      <= side3_r.sx;
    side4_r.sy      <= side3_r.sy;
    side4_r.r       <= side3_r.r;
    side4_r.adx     <= side3_r.adx;
    side4_r.ady     <= side3_r.ady;
    dsq4_r          <= dsq4_nxt;
  end

  assign out_valid = v4_r;
  assign out_dsq   = dsq4_r;
  assign out_side  = side4_r;

endmodule

FILE: src/cpop_sqrt.sv
// Pipelined integer square root, two result bits per stage.
module cpop_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [cpop_pkg::DSQ_W-1:0]   in_x,
  output logic                         out_valid,
  output logic [cpop_pkg::ROOT_W-1:0]  out_root
);

  logic                           v_r    [cpop_pkg::SQRT_STAGES];
  logic [cpop_pkg::SQRT_X_W-1:0]  x_r    [cpop_pkg::SQRT_STAGES];
  logic [cpop_pkg::REM_W-1:0]     rem_r  [cpop_pkg::SQRT_STAGES];
  logic [cpop_pkg::ROOT_W-1:0]    root_r [cpop_pkg::SQRT_STAGES];

  for (genvar s = 0; s < cpop_pkg::SQRT_STAGES; s++) begin : g_st
    logic                           vi;
    logic [cpop_pkg::SQRT_X_W-1:0]  xi, xo;
    logic [cpop_pkg::REM_W-1:0]     remi, remo, trial;
    logic [cpop_pkg::ROOT_W-1:0]    rooti, rooto;

    if (s == 0) begin : g_first
      assign vi    = in_valid;
      assign xi    = cpop_pkg::SQRT_X_W'(in_x);
      assign remi  = '0;
      assign rooti = '0;
    end else begin : g_next
      assign vi    = v_r[s-1];
      assign xi    = x_r[s-1];
      assign remi  = rem_r[s-1];
      assign rooti = root_r[s-1];
    end

    always_comb begin
      xo    = xi;
      remo  = remi;
      rooto = rooti;
      trial = '0;
      for (int j = 0; j < 2; j++) begin
        remo  = {remo[cpop_pkg::REM_W-3:0], xo[cpop_pkg::SQRT_X_W-1 -: 2]};
        xo    = {xo[cpop_pkg::SQRT_X_W-3:0], 2'b00};
        trial = cpop_pkg::REM_W'({rooto, 2'b01});
        if (remo >= trial) begin
          remo  = remo - trial;
          rooto = {rooto[cpop_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rooto = {rooto[cpop_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= vi;
      end
      x_r[s]    <= xo;
      rem_r[s]  <= remo;
      root_r[s] <= rooto;
    end
  end

  assign out_valid = v_r[cpop_pkg::SQRT_STAGES-1];
  assign out_root  = root_r[cpop_pkg::SQRT_STAGES-1];

endmodule

FILE: src/cpop_div.sv
// Two-lane pipelined restoring divider with a shared divisor, two quotient bits per stage.
module cpop_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [cpop_pkg::NUM_W-1:0]   in_num_x,
  input  logic [cpop_pkg::NUM_W-1:0]   in_num_y,
  input  logic [cpop_pkg::DEN_W-1:0]   in_den,
  output logic                         out_valid,
  output logic [cpop_pkg::QUO_W-1:0]   out_quo_x,
  output logic [cpop_pkg::QUO_W-1:0]   out_quo_y
);

  logic                          v_r    [cpop_pkg::DIV_STAGES];
  logic [cpop_pkg::NUM_W-1:0]    remx_r [cpop_pkg::DIV_STAGES];
  logic [cpop_pkg::NUM_W-1:0]    remy_r [cpop_pkg::DIV_STAGES];
  logic [cpop_pkg::DEN_W-1:0]    den_r  [cpop_pkg::DIV_STAGES];
  logic [cpop_pkg::QUO_W-1:0]    qx_r   [cpop_pkg::DIV_STAGES];
  logic [cpop_pkg::QUO_W-1:0]    qy_r   [cpop_pkg::DIV_STAGES];

  for (genvar s = 0; s < cpop_pkg::DIV_STAGES; s++) begin : g_st
    logic                         vi;
    logic [cpop_pkg::NUM_W-1:0]   rxi, ryi, rxo, ryo, sh;
    logic [cpop_pkg::DEN_W-1:0]   di;
    logic [cpop_pkg::QUO_W-1:0]   qxi, qyi, qxo, qyo;

    if (s == 0) begin : g_first
      assign vi  = in_valid;
      assign rxi = in_num_x;
      assign ryi = in_num_y;
      assign di  = in_den;
      assign qxi = '0;
      assign qyi = '0;
    end else begin : g_next
      assign vi  = v_r[s-1];
      assign rxi = remx_r[s-1];
      assign ryi = remy_r[s-1];
      assign di  = den_r[s-1];
      assign qxi = qx_r[s-1];
      assign qyi = qy_r[s-1];
    end

    // quotient is known to fit QUO_W bits, so start at the top quotient bit
    always_comb begin
      rxo = rxi;
      ryo = ryi;
      qxo = qxi;
      qyo = qyi;
      sh  = '0;
      for (int j = 0; j < 2; j++) begin
        if (s * 2 + j < cpop_pkg::QUO_W) begin
          sh = cpop_pkg::NUM_W'(di) << (cpop_pkg::QUO_W - 1 - (s * 2 + j));
          if (rxo >= sh) begin
            rxo = rxo - sh;
            qxo[cpop_pkg::QUO_W - 1 - (s * 2 + j)] = 1'b1;
          end
          if (ryo >= sh) begin
            ryo = ryo - sh;
            qyo[cpop_pkg::QUO_W - 1 - (s * 2 + j)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= vi;
      end
      remx_r[s] <= rxo;
      remy_r[s] <= ryo;
      den_r[s]  <= di;
      qx_r[s]   <= qxo;
      qy_r[s]   <= qyo;
    end
  end

  assign out_valid = v_r[cpop_pkg::DIV_STAGES-1];
  assign out_quo_x = qx_r[cpop_pkg::DIV_STAGES-1];
  assign out_quo_y = qy_r[cpop_pkg::DIV_STAGES-1];

endmodule

FILE: src/circle_pair_overlap_push.sv
// Top level: circle pair overlap resolution pipeline.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-------------------------
//  input    | in_a_x in_a_y in_a_radius in_b_x in_b_y ...  | start & !busy
//  result   | out_delta_a_x/_y out_delta_b_x/_y out_contact| out_strobe, one cycle
//
// One pair enters per clock; busy stays low, the pipeline never stalls.
// Each result reaches out_strobe via the front stages, the root unit (two bits per
// stage), the violation, product and numerator stages, the divider (two quotient
// bits per stage) and the output register. Synchronous reset clears all valid bits.
module circle_pair_overlap_push (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [cpop_pkg::COORD_WIDTH-1:0]   in_a_x,
  input  logic [cpop_pkg::COORD_WIDTH-1:0]   in_a_y,
  input  logic [cpop_pkg::FRACTION_BITS-1:0] in_a_radius,
  input  logic [cpop_pkg::COORD_WIDTH-1:0]   in_b_x,
  input  logic [cpop_pkg::COORD_WIDTH-1:0]   in_b_y,
  input  logic [cpop_pkg::FRACTION_BITS-1:0] in_b_radius,
  output logic                               out_strobe,
  output logic [cpop_pkg::COORD_WIDTH-1:0]   out_delta_a_x,
  output logic [cpop_pkg::COORD_WIDTH-1:0]   out_delta_a_y,
  output logic [cpop_pkg::COORD_WIDTH-1:0]   out_delta_b_x,
  output logic [cpop_pkg::COORD_WIDTH-1:0]   out_delta_b_y,
  output logic                               out_contact
);

  logic                          fr_valid;
  logic [cpop_pkg::DSQ_W-1:0]    fr_dsq;
  cpop_pkg::side_t               fr_side;

  logic                          sq_valid;
  logic [cpop_pkg::ROOT_W-1:0]   sq_root;
  cpop_pkg::side_t               side_sq_r [cpop_pkg::SQRT_STAGES];

  // violation stage
  logic                          vv_r;
  cpop_pkg::side_t               sidev_r;
  logic [cpop_pkg::RAD_W-1:0]    viol_r;
  // product stage
  logic                          vm_r;
  cpop_pkg::sign_t               sgnm_r;
  logic [cpop_pkg::RAD_W-1:0]    rm_r;
  logic [cpop_pkg::SQ_W-1:0]     px_r, py_r;
  // numerator stage
  logic                          vn_r;
  cpop_pkg::sign_t               sgnn_r;
  logic [cpop_pkg::NUM_W-1:0]    numx_r, numy_r;
  logic [cpop_pkg::DEN_W-1:0]    den_r;

  logic                          dv_valid;
  logic [cpop_pkg::QUO_W-1:0]    qx, qy;
  cpop_pkg::sign_t               sgn_dv_r [cpop_pkg::DIV_STAGES];

  logic                          strobe_r, contact_r;
  logic [cpop_pkg::COORD_WIDTH-1:0] dax_r, day_r, dbx_r, dby_r;
  logic [cpop_pkg::COORD_WIDTH-1:0] mx, my, dbx_nxt, dby_nxt;
  cpop_pkg::sign_t               sgn_last;

  assign busy = 1'b0;

  cpop_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start),
    .in_a_x      (in_a_x),
    .in_a_y      (in_a_y),
    .in_a_radius (in_a_radius),
    .in_b_x      (in_b_x),
    .in_b_y      (in_b_y),
    .in_b_radius (in_b_radius),
    .out_valid   (fr_valid),
    .out_dsq     (fr_dsq),
    .out_side    (fr_side)
  );

  cpop_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_x      (fr_dsq),
    .out_valid (sq_valid),
    .out_root  (sq_root)
  );

  // side data rides alongside the root stages
  always_ff @(posedge clk) begin
    side_sq_r[0] <= fr_side;
    for (int k = 1; k < cpop_pkg::SQRT_STAGES; k++) begin
      side_sq_r[k] <= side_sq_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r <= 1'b0;
      vm_r <= 1'b0;
      vn_r <= 1'b0;
    end else begin
      vv_r <= sq_valid;
      vm_r <= vv_r;
      vn_r <= vm_r;
    end
    sidev_r <= side_sq_r[cpop_pkg::SQRT_STAGES-1];
    // root < r whenever contact holds, so the low bits suffice
    viol_r  <= side_sq_r[cpop_pkg::SQRT_STAGES-1].r - sq_root[cpop_pkg::RAD_W-1:0];

    sgnm_r.contact <= sidev_r.contact;
    sgnm_r.sx      <= sidev_r.sx;
    sgnm_r.sy      <= sidev_r.sy;
    rm_r           <= sidev_r.r;
    px_r           <= sidev_r.adx * viol_r;
    py_r           <= sidev_r.ady * viol_r;

    sgnn_r <= sgnm_r;
    numx_r <= cpop_pkg::NUM_W'(px_r) + cpop_pkg::NUM_W'(rm_r);
    numy_r <= cpop_pkg::NUM_W'(py_r) + cpop_pkg::NUM_W'(rm_r);
    den_r  <= {rm_r, 1'b0};
  end

  cpop_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vn_r),
    .in_num_x  (numx_r),
    .in_num_y  (numy_r),
    .in_den    (den_r),
    .out_valid (dv_valid),
    .out_quo_x (qx),
    .out_quo_y (qy)
  );

  always_ff @(posedge clk) begin
    sgn_dv_r[0] <= sgnn_r;
    for (int k = 1; k < cpop_pkg::DIV_STAGES; k++) begin
      sgn_dv_r[k] <= sgn_dv_r[k-1];
    end
  end

  always_comb begin
    sgn_last = sgn_dv_r[cpop_pkg::DIV_STAGES-1];
    mx       = sgn_last.contact ? cpop_pkg::COORD_WIDTH'(qx) : '0;
    my       = sgn_last.contact ? cpop_pkg::COORD_WIDTH'(qy) : '0;
    dbx_nxt  = sgn_last.sx ? (~mx + 1'b1) : mx;
    dby_nxt  = sgn_last.sy ? (~my + 1'b1) : my;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv_valid;
    end
    contact_r <= sgn_last.contact;
    dbx_r     <= dbx_nxt;
    dby_r     <= dby_nxt;
    dax_r     <= ~dbx_nxt + 1'b1;
    day_r     <= ~dby_nxt + 1'b1;
  end

  assign out_strobe    = strobe_r;
  assign out_contact   = contact_r;
  assign out_delta_a_x = dax_r;
  assign out_delta_a_y = day_r;
  assign out_delta_b_x = dbx_r;
  assign out_delta_b_y = dby_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(cpop_pkg::LATENCY) out_strobe)
    else $error("item did not emerge after pipeline latency");

  a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_contact) |->
      (out_delta_b_x == '0 && out_delta_b_y == '0
       && out_delta_a_x == '0 && out_delta_a_y == '0))
    else $error("nonzero push without contact");

  a_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_delta_a_x + out_delta_b_x == '0
                    && out_delta_a_y + out_delta_b_y == '0))
    else $error("displacements not opposite");

endmodule
